>>> src/sorted_price_level_table_core_macros.svh
// Assertion helpers shared by the price level table RTL.
// Both macros expect clk and arst_n to be visible in the enclosing module.
`ifndef SORTED_PRICE_LEVEL_TABLE_CORE_MACROS_SVH
`define SORTED_PRICE_LEVEL_TABLE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPLT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/splt_pkg.sv
`timescale 1ns / 1ps

package splt_pkg;

	localparam int LEVELS = 64;
	localparam int IDX_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int CNT_W  = $clog2(LEVELS + 1);

	typedef struct packed {
		logic signed [31:0] price;
		logic signed [31:0] volume;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} ram_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_WRITE
	} state_t;

	// Signed 32-bit add that clips at the representable limits.
	function automatic logic signed [31:0] sat_add32(
		input logic signed [31:0] a,
		input logic signed [31:0] b
	);
		logic signed [32:0] s;
		logic signed [31:0] r;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage

>>> src/splt_ram.sv
`timescale 1ns / 1ps

module splt_ram import splt_pkg::*; (
	input  logic             clk,
	input  logic [IDX_W-1:0] rd_addr,
	input  ram_wr_t          wr,
	output entry_t           rd_data
);

	// One entry per price level, price and volume side by side.
	entry_t mem [LEVELS];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> src/sorted_price_level_table_core.sv
// The search issues one memory read per cycle, and opening a gap for an insert moves one
// entry per cycle. A start is accepted only while busy is low; busy drops in the cycle that
// carries done. Asynchronous active-low reset empties the table and idles the controller.
// The receiver cannot stall; done is high for a single cycle, and the result outputs hold
// their values until the next transaction writes new ones.
`timescale 1ns / 1ps
`include "sorted_price_level_table_core_macros.svh"

module sorted_price_level_table_core import splt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] price,
	input  logic signed [31:0] volume,
	output logic               done,
	output logic [5:0]         level_index,
	output logic signed [31:0] level_volume,
	output logic               existing_level,
	output logic               table_full,
	output logic [6:0]         level_count
);

	// The levels live in a single synchronous memory holding price and volume
	// together, kept in ascending price order over the occupied entries. Each
	// transaction walks the memory from entry zero, issuing one read per cycle
	// and comparing the data of the previous read. The first entry whose price
	// is not below the request decides: equal means a hit, greater means the
	// new level belongs at that position. Running off the end of the occupied
	// entries means the new level is appended. A new level is dropped when the table is full.
	//
	// An insert in the middle first moves the upper entries up by one, top
	// down, writing entry i + 1 with the data of entry i read in the previous
	// cycle while reading entry i - 1. The read and write addresses never
	// collide, so no forwarding is required. Unless the table is full, the
	// final write stores the new level or the updated volume; the result is registered.

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;

	logic signed [31:0] price_q;
	logic signed [31:0] volume_q;
	logic signed [31:0] old_vol_q;
	logic [IDX_W-1:0]  cmp_idx_q;
	logic [IDX_W-1:0]  sh_idx_q;
	logic [IDX_W-1:0]  pos_q;
	logic              hit_q;
	logic              full_q;

	logic [5:0]        idx_out_q;
	logic signed [31:0] vol_out_q;
	logic              hit_out_q;
	logic              full_out_q;

	logic [IDX_W-1:0]  rd_addr;
	ram_wr_t           ram_wr;
	entry_t            rd_data;

	logic              price_ge;
	logic              price_eq;
	logic              at_last;
	logic              tbl_full;
	logic [IDX_W-1:0]  last_idx;
	logic signed [31:0] sat_vol;

	splt_ram u_ram (
		.clk     (clk),
		.rd_addr (rd_addr),
		.wr      (ram_wr),
		.rd_data (rd_data)
	);

	assign price_ge = (rd_data.price >= price_q);
	assign price_eq = (rd_data.price == price_q);
	assign at_last  = (CNT_W'(cmp_idx_q) == count_q - CNT_W'(1));
	assign tbl_full = (count_q == CNT_W'(LEVELS));
	assign last_idx = IDX_W'(count_q - CNT_W'(1));
	assign sat_vol  = sat_add32(old_vol_q, volume_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		rd_addr     = cmp_idx_q + IDX_W'(1);
		ram_wr      = '0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = '0;
				if (start) begin
					state_d = (count_q == '0) ? ST_WRITE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (price_ge) begin
					if (price_eq || tbl_full) begin
						state_d = ST_WRITE;
					end else begin
						// Start moving entries from the top of the table.
						state_d = ST_SHIFT;
						rd_addr = last_idx;
					end
				end else if (at_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_SHIFT: begin
				ram_wr.we   = 1'b1;
				ram_wr.addr = sh_idx_q + IDX_W'(1);
				ram_wr.data = rd_data;
				rd_addr     = sh_idx_q - IDX_W'(1);
				if (sh_idx_q == pos_q) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				ram_wr.we           = !full_q;
				ram_wr.addr         = pos_q;
				ram_wr.data.price   = price_q;
				ram_wr.data.volume  = hit_q ? sat_vol : volume_q;
				state_d             = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state: level count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_WRITE);
			if (state_q == ST_WRITE && !hit_q && !full_q) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Transaction payload and search bookkeeping.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					price_q   <= price;
					volume_q  <= volume;
					cmp_idx_q <= '0;
					pos_q     <= '0;
					hit_q     <= 1'b0;
					full_q    <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (price_ge) begin
					pos_q     <= cmp_idx_q;
					hit_q     <= price_eq;
					old_vol_q <= rd_data.volume;
					full_q    <= !price_eq && tbl_full;
					sh_idx_q  <= last_idx;
				end else if (at_last) begin
					// Appending past the last level; position wraps only when full.
					pos_q  <= IDX_W'(count_q);
					full_q <= tbl_full;
				end else begin
					cmp_idx_q <= cmp_idx_q + IDX_W'(1);
				end
			end
			ST_SHIFT: begin
				sh_idx_q <= sh_idx_q - IDX_W'(1);
			end
			ST_WRITE: begin
				hit_out_q  <= hit_q;
				full_out_q <= full_q;
				if (full_q) begin
					idx_out_q <= '0;
					vol_out_q <= '0;
				end else begin
					idx_out_q <= 6'(pos_q);
					vol_out_q <= hit_q ? sat_vol : volume_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign level_index    = idx_out_q;
	assign level_volume   = vol_out_q;
	assign existing_level = hit_out_q;
	assign table_full     = full_out_q;
	assign level_count    = 7'(count_q);

	`SPLT_ASSERT_IMPL(a_count_range, 1'b1, count_q <= CNT_W'(LEVELS), "level count above capacity")
	`SPLT_ASSERT_IMPL(a_flags_excl, done_q, !(hit_out_q && full_out_q), "hit and full together")
	`SPLT_ASSERT_IMPL(a_full_count, done_q && full_out_q, tbl_full, "drop with free space")
	`SPLT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted start did not raise busy")
	`SPLT_ASSERT_IMPL(a_shift_bound, state_q == ST_SHIFT, sh_idx_q >= pos_q, "shift below insert point")

endmodule
